[rtl/slkt_pkg.sv]
// Package: shared constants, codes and control types for the sorted leaf key table.
`timescale 1ns / 1ps
package slkt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int KEY_W    = 32;
    localparam int REC_W    = 64;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOCATE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_INSIDE = 3'd2,
        ST_BEYOND = 3'd3,
        ST_BADIDX = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
    } t_ctl;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

[rtl/slkt_ctrl.sv]
// Controller: sequences capture/compare and execute of one command.
`timescale 1ns / 1ps
module slkt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic          i_m_tready,
    input  slkt_pkg::t_sts i_sts,
    output slkt_pkg::t_ctl o_ctl
);
    slkt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slkt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_s_tready  = 1'b0;
        o_ctl.latch = 1'b0;
        o_ctl.exec  = 1'b0;
        case (r_state)
            slkt_pkg::S_IDLE: begin
                o_s_tready  = 1'b1;
                o_ctl.latch = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = slkt_pkg::S_EXEC;
                end
            end
            slkt_pkg::S_EXEC: begin
                // wait for the output register to free up
                if (!i_sts.out_busy || i_m_tready) begin
                    o_ctl.exec = 1'b1;
                    n_state    = slkt_pkg::S_IDLE;
                end
            end
            default: n_state = slkt_pkg::S_IDLE;
        endcase
    end
endmodule

[rtl/slkt_dp.sv]
// Datapath: row of key/record cells, parallel compare, shift insert and result register.
`timescale 1ns / 1ps
module slkt_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  slkt_pkg::t_ctl                  i_ctl,
    output slkt_pkg::t_sts                  o_sts,
    input  logic [1:0]                      i_cmd,
    input  logic signed [slkt_pkg::KEY_W-1:0] i_key,
    input  logic [slkt_pkg::REC_W-1:0]      i_rec,
    input  logic [slkt_pkg::IDX_W-1:0]      i_idx,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [2:0]                      o_status,
    output logic [slkt_pkg::CNT_W-1:0]      o_found_index,
    output logic [slkt_pkg::KEY_W-1:0]      o_entry_key,
    output logic [slkt_pkg::REC_W-1:0]      o_entry_record,
    output logic [slkt_pkg::CNT_W-1:0]      o_entry_count
);
    logic signed [slkt_pkg::KEY_W-1:0] r_keys [slkt_pkg::CAPACITY];
    logic [slkt_pkg::REC_W-1:0]        r_recs [slkt_pkg::CAPACITY];
    logic [slkt_pkg::CNT_W-1:0]        r_count;

    logic [1:0]                        r_cmd;
    logic signed [slkt_pkg::KEY_W-1:0] r_key;
    logic [slkt_pkg::REC_W-1:0]        r_rec;
    logic [slkt_pkg::IDX_W-1:0]        r_idx;
    logic [slkt_pkg::CAPACITY-1:0]     r_lt;
    logic [slkt_pkg::CAPACITY-1:0]     r_eq;

    logic                              r_ovalid;
    logic [2:0]                        r_status;
    logic [slkt_pkg::CNT_W-1:0]        r_found;
    logic [slkt_pkg::KEY_W-1:0]        r_okey;
    logic [slkt_pkg::REC_W-1:0]        r_orec;
    logic [slkt_pkg::CNT_W-1:0]        r_ocount;

    logic [slkt_pkg::CNT_W-1:0]        pos;
    logic                              full;
    logic                              do_ins;

    assign o_sts.out_busy = r_ovalid;
    // keys are sorted, so the less-than flags form a prefix
    assign pos    = slkt_pkg::CNT_W'($countones(r_lt));
    assign full   = (r_count >= slkt_pkg::CNT_W'(slkt_pkg::CAPACITY));
    assign do_ins = i_ctl.exec && (r_cmd == slkt_pkg::CMD_INSERT) && !full;

    // capture the command and compare against every cell in parallel
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
            r_rec <= i_rec;
            r_idx <= i_idx;
            for (int j = 0; j < slkt_pkg::CAPACITY; j++) begin
                r_lt[j] <= (slkt_pkg::CNT_W'(j) < r_count) && (r_keys[j] < i_key);
                r_eq[j] <= (r_keys[j] == i_key);
            end
        end
    end

    // write the new entry at the insertion point and shift cells above it up by one
    always_ff @(posedge i_clk) begin
        if (do_ins) begin
            for (int j = 0; j < slkt_pkg::CAPACITY; j++) begin
                if (slkt_pkg::CNT_W'(j) == pos) begin
                    r_keys[j] <= r_key;
                    r_recs[j] <= r_rec;
                end else if (j > 0 && slkt_pkg::CNT_W'(j) > pos) begin
                    r_keys[j] <= r_keys[(j > 0) ? j - 1 : 0];
                    r_recs[j] <= r_recs[(j > 0) ? j - 1 : 0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (do_ins) begin
                r_count <= r_count + 1'b1;
            end
            if (i_ctl.exec) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_found  <= '0;
            r_okey   <= '0;
            r_orec   <= '0;
            r_status <= slkt_pkg::ST_OK;
            r_ocount <= r_count;
            case (r_cmd)
                slkt_pkg::CMD_INSERT: begin
                    if (full) begin
                        r_status <= slkt_pkg::ST_FULL;
                    end else begin
                        r_found  <= pos;
                        r_ocount <= r_count + 1'b1;
                    end
                end
                slkt_pkg::CMD_LOCATE: begin
                    r_found <= pos;
                    if (pos >= r_count) begin
                        r_status <= slkt_pkg::ST_BEYOND;
                    end else if (!r_eq[pos[slkt_pkg::IDX_W-1:0]]) begin
                        r_status <= slkt_pkg::ST_INSIDE;
                    end
                end
                slkt_pkg::CMD_READ: begin
                    if ({1'b0, r_idx} >= r_count) begin
                        r_status <= slkt_pkg::ST_BADIDX;
                    end else begin
                        r_okey <= r_keys[r_idx];
                        r_orec <= r_recs[r_idx];
                    end
                end
                default: r_status <= slkt_pkg::ST_BADIDX;
            endcase
        end
    end

    assign o_m_tvalid     = r_ovalid;
    assign o_status       = r_status;
    assign o_found_index  = r_found;
    assign o_entry_key    = r_okey;
    assign o_entry_record = r_orec;
    assign o_entry_count  = r_ocount;
endmodule

[rtl/sorted_leaf_key_table.sv]
// Top level: sorted leaf key table with stream ports.
// A beat is accepted and compared in the capture registers, then executed into the
//   result register by the controller; the next beat is accepted only after that
//   execute state, which waits while the previous result is stalled.
// Reset (i_rst_n low, synchronous): entry count cleared, no result pending;
//   cell contents are left as they are and never read before being written.
`timescale 1ns / 1ps
module sorted_leaf_key_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [103:0] i_s_tdata,  // key[31:0], record_id[95:32], entry_index[101:96], zero pad
    input  logic [1:0]   i_s_tuser,  // command[1:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [111:0] o_m_tdata,  // found_index[6:0], entry_key[38:7],
                                     // entry_record[102:39], entry_count[109:103], zero pad
    output logic [2:0]   o_m_tuser   // status[2:0]
);
    slkt_pkg::t_ctl ctl;
    slkt_pkg::t_sts sts;

    logic [slkt_pkg::CNT_W-1:0] found_index;
    logic [slkt_pkg::KEY_W-1:0] entry_key;
    logic [slkt_pkg::REC_W-1:0] entry_record;
    logic [slkt_pkg::CNT_W-1:0] entry_count;

    // controller: accept in idle, execute once the result register is free
    slkt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    // datapath: cells, compare flags, shift on insert, result register
    slkt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_cmd          (i_s_tuser),
        .i_key          (i_s_tdata[31:0]),
        .i_rec          (i_s_tdata[95:32]),
        .i_idx          (i_s_tdata[101:96]),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_status       (o_m_tuser),
        .o_found_index  (found_index),
        .o_entry_key    (entry_key),
        .o_entry_record (entry_record),
        .o_entry_count  (entry_count)
    );

    // pack result fields, lowest first
    assign o_m_tdata = {2'b00, entry_count, entry_record, entry_key, found_index};

    // the count reported never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (entry_count <= slkt_pkg::CNT_W'(slkt_pkg::CAPACITY)))
        else $error("entry count above capacity");

    // a full answer only comes with a full table
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == slkt_pkg::ST_FULL)
        |-> (entry_count == slkt_pkg::CNT_W'(slkt_pkg::CAPACITY)))
        else $error("full status with spare room");

    // one command at a time: no new beat right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready held after accept");

    // found index never passes the count
    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (found_index <= entry_count))
        else $error("found index past count");
endmodule
